/* hw/rtl/swmv_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swmv_pkg
// shared constants for the sliding window majority vote core
// ----------------------------------------------------------------------------
package swmv_pkg;

   localparam int WINDOW_DEF  = 9;
   localparam int CLASSES_DEF = 16;

   localparam int LABEL_W    = 8;
   localparam int DECISION_W = 4;
   localparam int FILL_W     = 4;

endpackage

`default_nettype wire

/* hw/rtl/swmv_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swmv_ram
// simple dual port memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module swmv_ram #(
   parameter int DEPTH  = 16,
   parameter int WIDTH  = 4,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic [ADDR_W-1:0] raddr,
   output      logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* hw/rtl/sliding_window_majority_vote_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_majority_vote_core
// mode filter over the last WINDOW class labels
// ----------------------------------------------------------------------------
// input channel req_*: one label word per item, valid/ready.
// result channel rsp_*: one word per item with the majority class (ties to
// the lowest index, 0 when empty), window-full flag, fill count and an
// accepted flag. labels at or above CLASSES leave the state untouched.
// per-class tallies sit in a memory of CLASSES entries, the labels in a ring
// memory of WINDOW entries.
// an in-range label passes, once the window is full, through eviction
// read/write, insertion read/write, a scan of the tallies, one class per
// cycle, and the done state, which raises rsp_valid; while the window
// fills the eviction steps are skipped. an out-of-range label reuses the
// stored decision and goes straight from idle to the done state. the next
// word can be accepted once the core is back in idle.
// one item is in flight at a time; req_ready is high only while idle.
// after reset a clearing pass zeroes the tally memory, with req_ready low.
// a result waits in the output register while the receiver stalls; the
// next word can be taken meanwhile, but its result waits until the output
// register is free.
// ----------------------------------------------------------------------------
module sliding_window_majority_vote_core #(
   parameter int WINDOW  = swmv_pkg::WINDOW_DEF,
   parameter int CLASSES = swmv_pkg::CLASSES_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            req_ready,
   input  wire logic [swmv_pkg::LABEL_W-1:0]    req_label,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      logic [swmv_pkg::DECISION_W-1:0] rsp_decision,
   output      logic                            rsp_ready_res,
   output      logic [swmv_pkg::FILL_W-1:0]     rsp_fill_count,
   output      logic                            rsp_accepted
);

   import swmv_pkg::*;

   localparam int LBL_W  = (CLASSES > 1) ? $clog2(CLASSES) : 1;
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SCAN_W = $clog2(CLASSES + 1);

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_EV_RD  = 4'd2;
   localparam logic [3:0] S_EV_WR  = 4'd3;
   localparam logic [3:0] S_NEW_RD = 4'd4;
   localparam logic [3:0] S_NEW_WR = 4'd5;
   localparam logic [3:0] S_SCAN   = 4'd6;
   localparam logic [3:0] S_DONE   = 4'd7;

   logic [3:0]       state_ff, state_in;
   logic [LBL_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic [LBL_W-1:0] lbl_ff, lbl_in;
   logic             acc_ff, acc_in;
   logic [POS_W-1:0] wpos_ff, wpos_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SCAN_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic             pend_ff, pend_in;
   logic [LBL_W-1:0] pend_cls_ff, pend_cls_in;
   logic [LBL_W-1:0] best_ff, best_in;
   logic [CNT_W-1:0] best_n_ff, best_n_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DECISION_W-1:0] rsp_decision_ff;
   logic                  rsp_ready_res_ff;
   logic [FILL_W-1:0]     rsp_fill_ff;
   logic                  rsp_accepted_ff;

   logic             tally_we;
   logic [LBL_W-1:0] tally_waddr, tally_raddr;
   logic [CNT_W-1:0] tally_wdata, tally_rd;
   logic             ring_we;
   logic [LBL_W-1:0] ring_rd;

   logic             full;
   logic             in_range;
   logic             scan_issue;
   logic             out_free;
   logic [LBL_W+3:0] best_ext;
   logic [CNT_W+3:0] count_ext;

   assign full       = (count_ff == CNT_W'(WINDOW));
   assign in_range   = (req_label < LABEL_W'(CLASSES));
   assign scan_issue = (scan_cnt_ff != SCAN_W'(CLASSES));
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign best_ext   = (LBL_W + 4)'(best_ff);
   assign count_ext  = (CNT_W + 4)'(count_ff);

   swmv_ram #(
      .DEPTH (CLASSES),
      .WIDTH (CNT_W)
   ) u_tally (
      .clock (clock),
      .we    (tally_we),
      .waddr (tally_waddr),
      .wdata (tally_wdata),
      .raddr (tally_raddr),
      .rdata (tally_rd)
   );

   swmv_ram #(
      .DEPTH (WINDOW),
      .WIDTH (LBL_W)
   ) u_ring (
      .clock (clock),
      .we    (ring_we),
      .waddr (wpos_ff),
      .wdata (lbl_ff),
      .raddr (wpos_ff),
      .rdata (ring_rd)
   );

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      lbl_in       = lbl_ff;
      acc_in       = acc_ff;
      wpos_in      = wpos_ff;
      count_in     = count_ff;
      scan_cnt_in  = scan_cnt_ff;
      pend_in      = 1'b0;
      pend_cls_in  = pend_cls_ff;
      best_in      = best_ff;
      best_n_in    = best_n_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      tally_we     = 1'b0;
      tally_waddr  = lbl_ff;
      tally_wdata  = tally_rd + CNT_W'(1);
      tally_raddr  = lbl_ff;
      ring_we      = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            tally_we    = 1'b1;
            tally_waddr = clr_cnt_ff;
            tally_wdata = '0;
            clr_cnt_in  = clr_cnt_ff + LBL_W'(1);
            if (clr_cnt_ff == LBL_W'(CLASSES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               lbl_in = req_label[LBL_W-1:0];
               acc_in = in_range;
               if (!in_range) begin
                  state_in = S_DONE;
               end else if (full) begin
                  state_in = S_EV_RD;
               end else begin
                  state_in = S_NEW_RD;
               end
            end
         end
         S_EV_RD: begin
            // ring read data holds the label being evicted
            tally_raddr = ring_rd;
            state_in    = S_EV_WR;
         end
         S_EV_WR: begin
            tally_we    = 1'b1;
            tally_waddr = ring_rd;
            tally_wdata = tally_rd - CNT_W'(1);
            state_in    = S_NEW_RD;
         end
         S_NEW_RD: begin
            tally_raddr = lbl_ff;
            state_in    = S_NEW_WR;
         end
         S_NEW_WR: begin
            tally_we    = 1'b1;
            tally_waddr = lbl_ff;
            tally_wdata = tally_rd + CNT_W'(1);
            ring_we     = 1'b1;
            wpos_in     = (wpos_ff == POS_W'(WINDOW - 1)) ? '0 : wpos_ff + POS_W'(1);
            if (!full) begin
               count_in = count_ff + CNT_W'(1);
            end
            scan_cnt_in = '0;
            best_in     = '0;
            best_n_in   = '0;
            state_in    = S_SCAN;
         end
         S_SCAN: begin
            if (scan_issue) begin
               tally_raddr = scan_cnt_ff[LBL_W-1:0];
               pend_in     = 1'b1;
               pend_cls_in = scan_cnt_ff[LBL_W-1:0];
               scan_cnt_in = scan_cnt_ff + SCAN_W'(1);
            end
            // strict compare keeps the lowest class on a tie
            if (pend_ff && (tally_rd > best_n_ff)) begin
               best_in   = pend_cls_ff;
               best_n_in = tally_rd;
            end
            if (!scan_issue && !pend_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         acc_ff       <= 1'b0;
         wpos_ff      <= '0;
         count_ff     <= '0;
         scan_cnt_ff  <= '0;
         pend_ff      <= 1'b0;
         best_ff      <= '0;
         best_n_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         acc_ff       <= acc_in;
         wpos_ff      <= wpos_in;
         count_ff     <= count_in;
         scan_cnt_ff  <= scan_cnt_in;
         pend_ff      <= pend_in;
         best_ff      <= best_in;
         best_n_ff    <= best_n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lbl_ff      <= lbl_in;
      pend_cls_ff <= pend_cls_in;
      if ((state_ff == S_DONE) && out_free) begin
         rsp_decision_ff  <= best_ext[DECISION_W-1:0];
         rsp_ready_res_ff <= full;
         rsp_fill_ff      <= count_ext[FILL_W-1:0];
         rsp_accepted_ff  <= acc_ff;
      end
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_decision   = rsp_decision_ff;
   assign rsp_ready_res  = rsp_ready_res_ff;
   assign rsp_fill_count = rsp_fill_ff;
   assign rsp_accepted   = rsp_accepted_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(WINDOW))
      else $error("fill count beyond window");

   a_fill_from_zero: assert property (@(posedge clock) disable iff (reset)
      !full |-> (CNT_W'(wpos_ff) == count_ff))
      else $error("write position out of step with fill count");

   a_reject_skips: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !in_range) |=> (state_ff == S_DONE))
      else $error("rejected word did not go straight to result");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("result raised outside done state");

   a_scan_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> !tally_we && !ring_we)
      else $error("memory written during tally scan");
`endif

endmodule

`default_nettype wire

/* verif/sliding_window_majority_vote_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_majority_vote_core_tb
// The bench opens with a short table of labels: out-of-range labels on an
// empty window, the first fill, a tie between classes, a full window and its
// wrap. Random labels follow, mostly in range and often drawn from a pair of
// hot classes so that majorities and ties keep changing. Results of typed
// rows are checked against the table, all others field by field against
// an in-bench mode filter. The input and result channels idle in several
// phases. One long receiver hold-off backs up the core and stalls its input.
// ----------------------------------------------------------------------------
module sliding_window_majority_vote_core_tb;

   import swmv_pkg::*;

   localparam int WIN         = WINDOW_DEF;
   localparam int NCLS        = CLASSES_DEF;
   localparam int DIR_N       = 25;
   localparam int PHASE_WORDS = 115;
   localparam int HOLD_CYCLES = 80;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [DECISION_W-1:0] decision;
      logic                  ready_res;
      logic [FILL_W-1:0]     fill_count;
      logic                  accepted;
   } vote_type;

   typedef struct packed {
      logic [LABEL_W-1:0] label;
      logic               typed;
      vote_type           want;
   } dir_row_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [LABEL_W-1:0]    req_label = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [DECISION_W-1:0] rsp_decision;
   logic                  rsp_ready_res;
   logic [FILL_W-1:0]     rsp_fill_count;
   logic                  rsp_accepted;

   // in-bench mode filter state
   logic [LABEL_W-1:0] ring_labels [WIN] = '{default: '0};
   int                 wr_slot = 0;
   int                 held    = 0;

   vote_type pending_votes [$];
   int    vote_errors    = 0;
   int    cycle_count    = 0;
   int    src_idle_pct   = 0;
   int    sink_stall_pct = 0;
   logic  hold_pending   = 1'b0;
   logic  hold_taken     = 1'b0;
   int    hold_left      = 0;

   dir_row_type directed_rows [DIR_N] = '{
      {8'd16,  1'b1, 4'd0, 1'b0, 4'd0, 1'b0},
      {8'd255, 1'b1, 4'd0, 1'b0, 4'd0, 1'b0},
      {8'd0,   1'b1, 4'd0, 1'b0, 4'd1, 1'b1},
      {8'd15,  1'b1, 4'd0, 1'b0, 4'd2, 1'b1},
      {8'd15,  1'b0, 10'd0},
      {8'd170, 1'b0, 10'd0},
      {8'd7,   1'b0, 10'd0},
      {8'd7,   1'b0, 10'd0},
      {8'd7,   1'b0, 10'd0},
      {8'd1,   1'b0, 10'd0},
      {8'd2,   1'b0, 10'd0},
      {8'd85,  1'b0, 10'd0},
      {8'd3,   1'b0, 10'd0},
      {8'd3,   1'b0, 10'd0},
      {8'd3,   1'b0, 10'd0},
      {8'd128, 1'b0, 10'd0},
      {8'd127, 1'b0, 10'd0},
      {8'd15,  1'b0, 10'd0},
      {8'd15,  1'b0, 10'd0},
      {8'd15,  1'b0, 10'd0},
      {8'd64,  1'b0, 10'd0},
      {8'd1,   1'b0, 10'd0},
      {8'd254, 1'b0, 10'd0},
      {8'd8,   1'b0, 10'd0},
      {8'd4,   1'b0, 10'd0}
   };

   sliding_window_majority_vote_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_label      (req_label),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_decision   (rsp_decision),
      .rsp_ready_res  (rsp_ready_res),
      .rsp_fill_count (rsp_fill_count),
      .rsp_accepted   (rsp_accepted)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic vote_type vote_after_label(input logic [LABEL_W-1:0] lbl);
      int       tally [NCLS];
      int       best;
      vote_type v;
      v.accepted = 1'b0;
      if (lbl < NCLS) begin
         ring_labels[wr_slot] = lbl;
         wr_slot = (wr_slot + 1 == WIN) ? 0 : wr_slot + 1;
         if (held < WIN)
            held++;
         v.accepted = 1'b1;
      end
      foreach (tally[c])
         tally[c] = 0;
      for (int i = 0; i < held; i++)
         tally[ring_labels[i]]++;
      // strict greater keeps the lowest class on a tie, and 0 when empty
      best = 0;
      for (int c = 1; c < NCLS; c++)
         if (tally[c] > tally[best])
            best = c;
      v.decision   = best[DECISION_W-1:0];
      v.ready_res  = (held == WIN);
      v.fill_count = held[FILL_W-1:0];
      return v;
   endfunction

   // entered and left just after a falling edge
   task automatic send_word(input logic [LABEL_W-1:0] lbl, input logic typed,
                            input vote_type want);
      vote_type v;
      while ($urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_label <= lbl;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      v = vote_after_label(lbl);
      pending_votes.push_back(typed ? want : v);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_pending && !hold_taken) begin
         rsp_ready  <= 1'b0;
         hold_left  <= HOLD_CYCLES;
         hold_taken <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= sink_stall_pct);
      end
   end

   always @(posedge clock) begin
      vote_type got;
      vote_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_decision, rsp_ready_res, rsp_fill_count, rsp_accepted};
         if (pending_votes.size() == 0) begin
            $display("%0t unexpected word: decision %0d ready %0d fill %0d accepted %0d",
                     $time, got.decision, got.ready_res, got.fill_count, got.accepted);
            vote_errors++;
         end else begin
            want = pending_votes.pop_front();
            if (got !== want) begin
               $display("%0t dec/rdy/fill/acc expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                        $time, want.decision, want.ready_res, want.fill_count, want.accepted,
                        got.decision, got.ready_res, got.fill_count, got.accepted);
               vote_errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sliding_window_majority_vote_core: mismatch");
         $finish;
      end
   end

   initial begin
      int   pick;
      logic [LABEL_W-1:0] lbl;
      logic [3:0] hot_a;
      logic [3:0] hot_b;
      hot_a = 4'd0;
      hot_b = 4'd15;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_N; i++)
         send_word(directed_rows[i].label, directed_rows[i].typed, directed_rows[i].want);

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin
               // long receiver hold-off while words keep coming
               src_idle_pct = 0;
               sink_stall_pct <= 0;
               hold_pending <= 1'b1;
            end
            1: begin
               src_idle_pct = 74;
               sink_stall_pct <= 0;
            end
            2: begin
               src_idle_pct = 0;
               sink_stall_pct <= 74;
            end
            3: begin
               src_idle_pct = 19;
               sink_stall_pct <= 19;
            end
            default: begin
               src_idle_pct = 0;
               sink_stall_pct <= 0;
            end
         endcase
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if ($urandom_range(15) == 0) begin
               hot_a = 4'($urandom_range(NCLS - 1));
               hot_b = 4'($urandom_range(NCLS - 1));
            end
            pick = $urandom_range(99);
            if (pick < 20)
               lbl = LABEL_W'($urandom_range(255, NCLS));
            else if (pick < 55)
               lbl = $urandom_range(1) ? LABEL_W'(hot_a) : LABEL_W'(hot_b);
            else
               lbl = LABEL_W'($urandom_range(NCLS - 1));
            send_word(lbl, 1'b0, '0);
         end
      end
      req_valid <= 1'b0;

      while (pending_votes.size() != 0)
         @(posedge clock);
      repeat (NCLS + 8) @(posedge clock);
      if (vote_errors == 0)
         $display("sliding_window_majority_vote_core: match");
      else
         $display("sliding_window_majority_vote_core: mismatch");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/swmv_pkg.sv
hw/rtl/swmv_ram.sv
hw/rtl/sliding_window_majority_vote_core.sv
verif/sliding_window_majority_vote_core_tb.sv
